// ===== src/dhoat_pkg.sv =====
// Shared types, codes and sizes for the double-hash open-address key table.
package dhoat_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int KEY_W       = 32;
  localparam int HASH_W      = 16;
  localparam int HBIT_W      = $clog2(HASH_W);
  localparam int CFG_W       = 11;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_BAD    = 2'd3;

  localparam logic [1:0] STS_DONE = 2'd0;
  localparam logic [1:0] STS_FULL = 2'd1;
  localparam logic [1:0] STS_DUP  = 2'd2;
  localparam logic [1:0] STS_MISS = 2'd3;

  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_USED  = 2'd1;
  localparam logic [1:0] TAG_GONE  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key;
    logic [15:0] hash_one;
    logic [15:0] hash_two;
  } in_item_t;

  typedef struct packed {
    logic        success;
    logic [1:0]  status;
    logic [31:0] found_key;
    logic [10:0] entry_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [1:0]        wtag;
    logic              key_we;
    logic [KEY_W-1:0]  wkey;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] ra;
    logic [ADDR_W-1:0] rb;
  } mod_stat_t;

endpackage

// ===== src/dhoat_mod_unit.sv =====
// Bit-serial remainder unit: reduces both hashes modulo the active slot count.
module dhoat_mod_unit import dhoat_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HASH_W-1:0] a_in,
  input  logic [HASH_W-1:0] b_in,
  input  logic [CNT_W-1:0]  n_in,
  output mod_stat_t         stat
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [HBIT_W-1:0] cnt_r, cnt_nxt;
  logic [HASH_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [ADDR_W-1:0] ra_r, ra_nxt, rb_r, rb_nxt;
  logic [CNT_W-1:0]  sha, shb;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    ra_nxt   = ra_r;
    rb_nxt   = rb_r;
    // one dividend bit per cycle; remainder stays below n, so one subtract
    sha = {ra_r, a_r[HASH_W-1]};
    shb = {rb_r, b_r[HASH_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = a_in;
      b_nxt    = b_in;
      ra_nxt   = '0;
      rb_nxt   = '0;
    end else if (busy_r) begin
      ra_nxt  = (sha >= n_in) ? ADDR_W'(sha - n_in) : ADDR_W'(sha);
      rb_nxt  = (shb >= n_in) ? ADDR_W'(shb - n_in) : ADDR_W'(shb);
      a_nxt   = {a_r[HASH_W-2:0], 1'b0};
      b_nxt   = {b_r[HASH_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == HBIT_W'(HASH_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    ra_r <= ra_nxt;
    rb_r <= rb_nxt;
  end

  assign stat.done = done_r;
  assign stat.ra   = ra_r;
  assign stat.rb   = rb_r;

endmodule

// ===== src/dhoat_store.sv =====
// Slot tag and key memories, one write and one registered read per cycle.
module dhoat_store import dhoat_pkg::*; (
  input  logic             clk,
  input  store_req_t       req,
  output logic [1:0]       rd_tag,
  output logic [KEY_W-1:0] rd_key
);

  logic [1:0]       tag_mem [TABLE_DEPTH];
  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [1:0]       rd_tag_r;
  logic [KEY_W-1:0] rd_key_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      tag_mem[req.waddr] <= req.wtag;
    end
    rd_tag_r <= tag_mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (req.key_we) begin
      key_mem[req.waddr] <= req.wkey;
    end
    rd_key_r <= key_mem[req.raddr];
  end

  assign rd_tag = rd_tag_r;
  assign rd_key = rd_key_r;

endmodule

// ===== src/double_hash_open_address_table.sv =====
// Top level: request sequencer, probe walk, configuration register and result register.
//
// After reset the block runs a clearing pass over all 1024 slot tags and holds in_stall
// high meanwhile; configuration writes are taken during it. An accepted request first
// waits in ST_MOD on the bit-serial remainder unit, which reduces both hashes modulo the
// slot count in 16 bit steps, then takes a memory read state (ST_READ) and an evaluation
// state (ST_EVAL) for each slot probed, from one up to the effective slot count, since
// each probe waits on the registered read of the slot memory, and ends in ST_DONE, which
// places the result. The block returns to idle as the result is placed, so the next
// request can then be accepted. An insert refused as full, and command 3, skip the
// remainder unit and the probe walk and go straight from idle to ST_DONE. A result held
// by out_stall delays the next one by the length of the stall. One request is in flight
// at a time; the result register lets the next request be accepted while a result still
// waits on out_stall.
module double_hash_open_address_table import dhoat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t            state_r, state_nxt;
  logic [1:0]        cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt, n_eff;
  logic [ADDR_W-1:0] pos_r, pos_nxt, step_r, step_nxt;
  logic [CNT_W-1:0]  probe_r, probe_nxt;
  logic              free_found_r, free_found_nxt;
  logic [ADDR_W-1:0] free_pos_r, free_pos_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [CFG_W-1:0]  slots_r;
  out_item_t         pend_r, pend_nxt, out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  store_req_t        st_req;
  logic [1:0]        rd_tag;
  logic [KEY_W-1:0]  rd_key;
  logic              mod_start;
  mod_stat_t         mod_st;

  logic              hit, empty, last, free_any;
  logic [ADDR_W-1:0] free_at, pos_adv;
  logic [CNT_W-1:0]  pos_sum;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (!paddr[2]) ? 32'(slots_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= CFG_W'(TABLE_DEPTH);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      slots_r <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (slots_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(slots_r) > TABLE_DEPTH) begin
      n_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      n_eff = CNT_W'(slots_r);
    end
  end

  dhoat_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .a_in  (in_data.hash_one),
    .b_in  (in_data.hash_two),
    .n_in  (n_r),
    .stat  (mod_st)
  );

  dhoat_store u_store (
    .clk    (clk),
    .req    (st_req),
    .rd_tag (rd_tag),
    .rd_key (rd_key)
  );

  // probe evaluation terms
  assign hit      = (rd_tag == TAG_USED) && (rd_key == key_r);
  assign empty    = (rd_tag == TAG_EMPTY);
  assign last     = (probe_r == n_r - 1'b1);
  assign free_any = free_found_r || (rd_tag == TAG_GONE);
  assign free_at  = free_found_r ? free_pos_r : pos_r;
  assign pos_sum  = {1'b0, pos_r} + {1'b0, step_r};
  assign pos_adv  = (pos_sum >= n_r) ? ADDR_W'(pos_sum - n_r) : ADDR_W'(pos_sum);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    n_nxt          = n_r;
    pos_nxt        = pos_r;
    step_nxt       = step_r;
    probe_nxt      = probe_r;
    free_found_nxt = free_found_r;
    free_pos_nxt   = free_pos_r;
    count_nxt      = count_r;
    clr_nxt        = clr_r;
    pend_nxt       = pend_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    mod_start      = 1'b0;
    st_req         = '0;
    st_req.raddr   = pos_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        st_req.we    = 1'b1;
        st_req.waddr = clr_r;
        st_req.wtag  = TAG_EMPTY;
        clr_nxt      = clr_r + 1'b1;
        if (clr_r == ADDR_W'(TABLE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt              = in_data.command;
          key_nxt              = in_data.key[KEY_W-1:0];
          n_nxt                = n_eff;
          pend_nxt.success     = 1'b0;
          pend_nxt.found_key   = '0;
          pend_nxt.entry_count = 11'(count_r);
          if (in_data.command == CMD_BAD) begin
            pend_nxt.status = STS_MISS;
            state_nxt       = ST_DONE;
          end else if (in_data.command == CMD_INSERT && count_r >= n_eff) begin
            pend_nxt.status = STS_FULL;
            state_nxt       = ST_DONE;
          end else begin
            mod_start = 1'b1;
            state_nxt = ST_MOD;
          end
        end
      end

      ST_MOD: begin
        if (mod_st.done) begin
          pos_nxt        = mod_st.ra;
          step_nxt       = mod_st.rb;
          probe_nxt      = '0;
          free_found_nxt = 1'b0;
          state_nxt      = ST_READ;
        end
      end

      ST_READ: begin
        state_nxt = ST_EVAL;
      end

      ST_EVAL: begin
        pend_nxt.success     = 1'b0;
        pend_nxt.status      = STS_MISS;
        pend_nxt.found_key   = '0;
        pend_nxt.entry_count = 11'(count_r);
        state_nxt            = ST_DONE;
        if (cmd_r == CMD_INSERT) begin
          if (hit) begin
            pend_nxt.status = STS_DUP;
          end else if (empty || (last && free_any)) begin
            // fill the first free slot seen on the path
            st_req.we            = 1'b1;
            st_req.key_we        = 1'b1;
            st_req.waddr         = free_at;
            st_req.wtag          = TAG_USED;
            st_req.wkey          = key_r;
            count_nxt            = count_r + 1'b1;
            pend_nxt.success     = 1'b1;
            pend_nxt.status      = STS_DONE;
            pend_nxt.entry_count = 11'(count_r + 1'b1);
          end else if (!last) begin
            free_found_nxt = free_any;
            free_pos_nxt   = free_at;
            pos_nxt        = pos_adv;
            probe_nxt      = probe_r + 1'b1;
            state_nxt      = ST_READ;
          end
        end else begin
          if (hit) begin
            pend_nxt.success   = 1'b1;
            pend_nxt.status    = STS_DONE;
            pend_nxt.found_key = 32'(rd_key);
            if (cmd_r == CMD_REMOVE) begin
              st_req.we    = 1'b1;
              st_req.waddr = pos_r;
              st_req.wtag  = TAG_GONE;
              if (count_r != '0) begin
                count_nxt            = count_r - 1'b1;
                pend_nxt.entry_count = 11'(count_r - 1'b1);
              end
            end
          end else if (!empty && !last) begin
            pos_nxt   = pos_adv;
            probe_nxt = probe_r + 1'b1;
            state_nxt = ST_READ;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    n_r          <= n_nxt;
    pos_r        <= pos_nxt;
    step_r       <= step_nxt;
    probe_r      <= probe_nxt;
    free_found_r <= free_found_nxt;
    free_pos_r   <= free_pos_nxt;
    pend_r       <= pend_nxt;
    out_r        <= out_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("occupied count above table depth");

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> (probe_r < n_r))
    else $error("probe walk ran past slot count");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    st_req.we |-> (state_r == ST_CLEAR || state_r == ST_EVAL))
    else $error("slot write outside clear or evaluation");

  a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
    mod_st.done |-> (state_r == ST_MOD))
    else $error("remainder result outside its wait state");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !(out_valid_r && out_stall)) |=> out_valid_r)
    else $error("finished request not placed in result register");

endmodule
